@@ sv/ur_alarm_pkg.sv @@
// Shared constants, item kinds and the divide-by-33 helper for the ranger alarm.
`default_nettype none
package ur_alarm_pkg;

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_CAPTURE = 1'b1
  } kind_e;

  // register indexes on the config port, taken from paddr[2]
  localparam logic REG_TRIGGER_PERIOD = 1'b0;
  localparam logic REG_RELEASE_COUNT  = 1'b1;

  localparam logic [15:0] TRIGGER_PERIOD_RST = 16'd1500;
  localparam logic [7:0]  RELEASE_COUNT_RST  = 8'd10;

  // echo ticks for 200 mm and 50 mm
  localparam logic [15:0] NEAR_LIMIT  = 16'd16500;
  localparam logic [15:0] CLOSE_LIMIT = 16'd4125;

  localparam logic [12:0] DUTY_MAX  = 13'd5999;
  localparam logic [13:0] DUTY_BASE = 14'd7999;
  localparam logic [12:0] DUTY_IDLE = 13'd1;

  // floor(x/33) for x < 2**19: multiply by ceil(2**24/33), exact over that range
  localparam int          DIV33_SHIFT = 24;
  localparam logic [18:0] DIV33_MULT  = 19'd508401;

  function automatic logic [13:0] div33(input logic [18:0] x);
    logic [37:0] prod;
    prod = {19'd0, x} * {19'd0, DIV33_MULT};
    return prod[DIV33_SHIFT +: 14];
  endfunction

endpackage
`default_nettype wire

@@ sv/ultrasonic_ranger_proximity_alarm.sv @@
// Ultrasonic ranger with proximity buzzer: trigger timing, echo pairing, distance and duty.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: capture_value; tuser: kind
//  m_axis    out  tvalid/tready             tdata: trigger, echo_ticks, distance, duty
//  apb       in   psel/penable/pwrite       paddr, pwdata, prdata; pready tied high
//
// One word per cycle while m_axis is ready. A word is held in the input register, then the
// state update and the result (one constant multiply by 1/33 per path) are registered
// together into the output register.
// Reset (rst_ni low, async) clears all tracking state and loads the register defaults.
// A stall on m_axis holds the output; the input register still takes one more word.
`default_nettype none
module ultrasonic_ranger_proximity_alarm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] capture_value
  input  wire logic        s_axis_tuser,  // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] trigger, [16:1] echo_ticks, [29:17] distance_tenths_mm, [42:30] alarm_duty,
  // [47:43] zero
  output logic [47:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [15:0] period_q;
  logic [7:0]  rel_count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= ur_alarm_pkg::TRIGGER_PERIOD_RST;
      rel_count_q <= ur_alarm_pkg::RELEASE_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        ur_alarm_pkg::REG_TRIGGER_PERIOD: period_q    <= pwdata[15:0];
        ur_alarm_pkg::REG_RELEASE_COUNT:  rel_count_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ur_alarm_pkg::REG_TRIGGER_PERIOD: prdata = {16'd0, period_q};
      ur_alarm_pkg::REG_RELEASE_COUNT:  prdata = {24'd0, rel_count_q};
      default:                          prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic in_v_q, out_v_q;
  logic adv, in_ready, fire;

  assign adv           = !out_v_q || m_axis_tready;
  assign in_ready      = !in_v_q || adv;
  assign fire          = in_v_q && adv;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_v_q;

  // input register
  ur_alarm_pkg::kind_e in_kind_q;
  logic [15:0]         in_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      in_kind_q <= ur_alarm_pkg::kind_e'(s_axis_tuser);
      in_cap_q  <= s_axis_tdata;
    end
  end

  // tracking state
  logic [15:0] cnt_q, cnt_d;
  logic        trig_q, trig_d;
  logic        armed_q, armed_d;
  logic        wait_q, wait_d;
  logic [15:0] start_q, start_d;
  logic [15:0] end_q, end_d;
  logic [15:0] echo_q, echo_d;
  logic [7:0]  rel_q, rel_d;
  logic [12:0] duty_q, duty_d;

  logic        is_tick;
  logic        near, close;
  logic [18:0] drop_num;
  logic [13:0] drop;
  logic [12:0] duty_calc;
  logic [13:0] dist_full;

  assign is_tick   = (in_kind_q == ur_alarm_pkg::KIND_TICK);
  assign near      = echo_q < ur_alarm_pkg::NEAR_LIMIT;
  assign close     = echo_q < ur_alarm_pkg::CLOSE_LIMIT;
  // ceil(d*16/33) = floor((16d+32)/33); only used while d < 16500, so 15 bits of d suffice
  assign drop_num  = {echo_q[14:0], 4'b0000} + 19'd32;
  assign drop      = ur_alarm_pkg::div33(drop_num);
  assign duty_calc = (drop > ur_alarm_pkg::DUTY_BASE) ? 13'd0
                                                      : 13'(ur_alarm_pkg::DUTY_BASE - drop);

  always_comb begin
    cnt_d   = cnt_q;
    trig_d  = trig_q;
    armed_d = armed_q;
    wait_d  = wait_q;
    start_d = start_q;
    end_d   = end_q;
    rel_d   = rel_q;
    duty_d  = duty_q;
    if (is_tick) begin
      cnt_d = (cnt_q < period_q) ? cnt_q + 16'd1 : 16'd0;
      if (near) begin
        rel_d  = 8'd0;
        duty_d = close ? ur_alarm_pkg::DUTY_MAX : duty_calc;
      end else if (rel_q == rel_count_q) begin
        rel_d  = 8'd0;
        duty_d = ur_alarm_pkg::DUTY_IDLE;
      end else begin
        rel_d = rel_q + 8'd1;
      end
      if (cnt_d == 16'd0) begin
        trig_d = 1'b1;
      end else if (trig_q) begin
        trig_d  = 1'b0;
        armed_d = 1'b1;
      end
    end else begin
      if (wait_q) begin
        end_d  = in_cap_q;
        wait_d = 1'b0;
      end else if (armed_q) begin
        start_d = in_cap_q;
        armed_d = 1'b0;
        wait_d  = 1'b1;
      end
    end
    echo_d = is_tick ? echo_q : start_d - end_d;
  end

  assign dist_full = ur_alarm_pkg::div33({1'b0, echo_d, 2'b00});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      trig_q  <= 1'b0;
      armed_q <= 1'b0;
      wait_q  <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
      echo_q  <= '0;
      rel_q   <= '0;
      duty_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q   <= cnt_d;
        trig_q  <= trig_d;
        armed_q <= armed_d;
        wait_q  <= wait_d;
        start_q <= start_d;
        end_q   <= end_d;
        echo_q  <= echo_d;
        rel_q   <= rel_d;
        duty_q  <= duty_d;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  // result register
  logic [47:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {5'd0, duty_d, dist_full[12:0], echo_d, (cnt_d == 16'd0)};
    end
  end

  assign m_axis_tdata = out_data_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  a_trig_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_q |-> (cnt_q == 16'd0))
    else $error("trigger flag set with nonzero tick counter");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= ur_alarm_pkg::DUTY_MAX)
    else $error("duty above maximum");

  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_v_q)
    else $error("accepted word not held in input register");
`endif

endmodule
`default_nettype wire

@@ tb/sv/ultrasonic_ranger_proximity_alarm_test.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the ultrasonic ranger proximity alarm.
module ultrasonic_ranger_proximity_alarm_test;
  import ur_alarm_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 130;
  localparam int PRESSURE_PHASE  = 3;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 1000;

  // laid out to match m_axis_tdata[42:0]
  typedef struct packed {
    logic [12:0] duty;
    logic [12:0] distance;
    logic [15:0] echo_ticks;
    logic        trigger;
  } range_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_PERIOD, ROW_RELEASE} row_op_e;

  typedef struct packed {
    row_op_e     op;
    kind_e       kind;
    logic [15:0] value;
    logic        typed;
    range_word_t want;
  } plan_row_t;

  localparam range_word_t NO_WANT = '0;
  localparam int PLAN_ROWS = 32;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // out of reset: near echo, counter leaves 0 with no trigger seen
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b1, '{13'd5999, 13'd0, 16'd0, 1'b0}},
    // edge while capture is not armed is dropped
    '{ROW_WORD,    KIND_CAPTURE, 16'hFFFF, 1'b1, '{13'd5999, 13'd0, 16'd0, 1'b0}},
    // zero period pins the counter at 0, trigger stays high
    '{ROW_PERIOD,  KIND_TICK,    16'd0,    1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b1, '{13'd5999, 13'd0, 16'd0, 1'b1}},
    '{ROW_WORD,    KIND_TICK,    16'hFFFF, 1'b1, '{13'd5999, 13'd0, 16'd0, 1'b1}},
    '{ROW_PERIOD,  KIND_TICK,    16'hFFFF, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // period dropped under the counter: wraps on the next tick
    '{ROW_PERIOD,  KIND_TICK,    16'd1,    1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // longest echo, largest distance
    '{ROW_WORD,    KIND_CAPTURE, 16'hFFFF, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_CAPTURE, 16'h0000, 1'b0, NO_WANT},
    '{ROW_RELEASE, KIND_TICK,    16'd0,    1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_RELEASE, KIND_TICK,    16'd255,  1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // close echo
    '{ROW_WORD,    KIND_CAPTURE, 16'h03E8, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_CAPTURE, 16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // first far echo
    '{ROW_WORD,    KIND_CAPTURE, 16'h4074, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_CAPTURE, 16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // last near echo: duty goes negative and clamps to 0
    '{ROW_WORD,    KIND_CAPTURE, 16'h4073, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_CAPTURE, 16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT},
    // first echo outside the close band
    '{ROW_WORD,    KIND_CAPTURE, 16'h101D, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_CAPTURE, 16'h0000, 1'b0, NO_WANT},
    '{ROW_WORD,    KIND_TICK,    16'h0000, 1'b0, NO_WANT}
  };

  localparam logic [15:0] EDGE_SPANS [6] = '{16'd4124, 16'd4125, 16'd16499, 16'd16500,
                                             16'd0, 16'hFFFF};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = KIND_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ultrasonic_ranger_proximity_alarm u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ranger state as the block should hold it
  logic [15:0] period_cfg    = TRIGGER_PERIOD_RST;
  logic [7:0]  release_cfg   = RELEASE_COUNT_RST;
  logic [15:0] tick_count    = '0;
  logic        trigger_seen  = 1'b0;
  logic        capture_armed = 1'b0;
  logic        awaiting_end  = 1'b0;
  logic [15:0] start_stamp   = '0;
  logic [15:0] end_stamp     = '0;
  logic [15:0] echo_time     = '0;
  logic [7:0]  far_ticks     = '0;
  logic [12:0] duty_now      = '0;

  range_word_t range_q[$];
  int          fail_count = 0;
  int          idle_count = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  bit          hold_req = 1'b0;
  range_word_t seen_word;
  range_word_t want_word;

  function automatic range_word_t ranger_step(input kind_e kind, input logic [15:0] cap,
                                              output bit skipped);
    range_word_t r;
    int drop;
    skipped = 1'b0;
    if (kind == KIND_TICK) begin
      tick_count = (tick_count < period_cfg) ? tick_count + 16'd1 : 16'd0;
      if (echo_time < NEAR_LIMIT) begin
        far_ticks = '0;
        if (echo_time < CLOSE_LIMIT) begin
          duty_now = DUTY_MAX;
        end else begin
          drop = (int'(echo_time) * 16 + 32) / 33;
          duty_now = (drop > int'(DUTY_BASE)) ? 13'd0 : 13'(int'(DUTY_BASE) - drop);
        end
      end else if (far_ticks == release_cfg) begin
        duty_now = DUTY_IDLE;
        far_ticks = '0;
      end else begin
        far_ticks = far_ticks + 8'd1;
      end
      if (tick_count == '0) begin
        trigger_seen = 1'b1;
      end else if (trigger_seen) begin
        trigger_seen = 1'b0;
        capture_armed = 1'b1;
      end
    end else begin
      if (awaiting_end) begin
        end_stamp = cap;
        awaiting_end = 1'b0;
      end else if (capture_armed) begin
        start_stamp = cap;
        capture_armed = 1'b0;
        awaiting_end = 1'b1;
      end else begin
        skipped = 1'b1;
      end
      echo_time = start_stamp - end_stamp;
    end
    r.trigger    = (tick_count == '0);
    r.echo_ticks = echo_time;
    r.distance   = 13'((int'(echo_time) * 4) / 33);
    r.duty       = duty_now;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_word(input kind_e kind, input logic [15:0] cap, output bit skipped,
                           input bit typed = 1'b0, input range_word_t want = '0);
    range_word_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= cap;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = ranger_step(kind, cap, skipped);
    range_q.push_back(typed ? want : predicted);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (range_q.size() != 0) @(posedge clk_i);
  endtask

  // write, then read back through the same port
  task automatic write_reg(input logic idx, input logic [15:0] val);
    logic [31:0] wdata;
    logic [15:0] held;
    wdata = $urandom();
    if (idx == REG_TRIGGER_PERIOD) wdata[15:0] = val;
    else wdata[7:0] = val[7:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_TRIGGER_PERIOD) period_cfg = wdata[15:0];
    else release_cfg = wdata[7:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    held = (idx == REG_TRIGGER_PERIOD) ? prdata[15:0] : {8'd0, prdata[7:0]};
    check_field(idx == REG_TRIGGER_PERIOD ? "trigger_period readback" : "release_count readback",
                (idx == REG_TRIGGER_PERIOD) ? int'(period_cfg) : int'(release_cfg), int'(held));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = m_axis_tdata[42:0];
      if (range_q.size() == 0) begin
        $display("%0t ns: result word expected none actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want_word = range_q.pop_front();
        check_field("trigger", want_word.trigger, seen_word.trigger);
        check_field("echo_ticks", want_word.echo_ticks, seen_word.echo_ticks);
        check_field("distance_tenths_mm", want_word.distance, seen_word.distance);
        check_field("alarm_duty", want_word.duty, seen_word.duty);
        check_field("pad bits", 0, m_axis_tdata[47:43]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, idle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // result side: random stalls, ready bursts, and one long hold on request
  initial begin : result_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    bit          skipped;
    int          counted;
    int          seq_len;
    logic [15:0] period_val;
    logic [7:0]  release_val;
    logic [15:0] start_v;
    logic [15:0] span;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (DIRECTED_PLAN[i].op)
        ROW_PERIOD: begin
          drain();
          write_reg(REG_TRIGGER_PERIOD, DIRECTED_PLAN[i].value);
        end
        ROW_RELEASE: begin
          drain();
          write_reg(REG_RELEASE_COUNT, DIRECTED_PLAN[i].value);
        end
        default: begin
          send_word(DIRECTED_PLAN[i].kind, DIRECTED_PLAN[i].value, skipped,
                    DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end
      endcase
    end

    // last phase runs with no idling on either side
    for (int phase = 0; phase <= RANDOM_PHASES; phase++) begin
      drain();
      if (phase == RANDOM_PHASES) begin
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
      end else begin
        src_gaps_on = (phase != PRESSURE_PHASE);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;

      case ($urandom_range(0, 9))
        0:       period_val = 16'd0;
        1:       period_val = 16'hFFFF;
        2:       period_val = 16'($urandom_range(1, 65535));
        default: period_val = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       release_val = 8'd0;
        1:       release_val = 8'd255;
        2:       release_val = 8'($urandom_range(16, 255));
        default: release_val = 8'($urandom_range(0, 12));
      endcase
      write_reg(REG_TRIGGER_PERIOD, period_val);
      write_reg(REG_RELEASE_COUNT, {8'd0, release_val});

      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: lone word of either kind
          send_word(kind_e'($urandom_range(0, 1)), 16'($urandom()), skipped);
          if (!skipped) counted++;
        end else begin
          // enough ticks to usually pass a trigger, then a start/end pair
          seq_len = $urandom_range(1, (period_val < 16'd14) ? int'(period_val) + 2 : 16);
          repeat (seq_len) begin
            send_word(KIND_TICK, 16'($urandom()), skipped);
            counted++;
          end
          start_v = 16'($urandom());
          case ($urandom_range(0, 3))
            0:       span = 16'($urandom_range(0, 4124));
            1:       span = 16'($urandom_range(4125, 16499));
            2:       span = 16'($urandom_range(16500, 65535));
            default: span = EDGE_SPANS[$urandom_range(0, 5)];
          endcase
          send_word(KIND_CAPTURE, start_v, skipped);
          if (!skipped) counted++;
          send_word(KIND_CAPTURE, start_v - span, skipped);
          if (!skipped) counted++;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ur_alarm_pkg.sv
sv/ultrasonic_ranger_proximity_alarm.sv
tb/sv/ultrasonic_ranger_proximity_alarm_test.sv
